FILE: hw/rtl/lssf_pkg.sv
package lssf_pkg;

  // Fixed widths of the register file and of the result.
  localparam int WINDOW_W  = 8;
  localparam int INV_W     = 32;
  localparam int SLOPE_W   = 34;
  localparam int CFG_IDX_W = 1;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_WIN_LEN   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_DENOM = 1'b1;

  // Reset values of the configuration registers.
  localparam logic [WINDOW_W-1:0] WINDOW_RESET = 8'd80;
  localparam logic [INV_W-1:0]    INV_RESET    = 32'd8390;

  // Integer tap weights run from -6(W-1) up in steps of 12; with W at most
  // 255 they stay within a 12-bit signed value.
  localparam int WGT_W       = 12;
  localparam int WGT_STEP    = 12;
  localparam int WGT_HALF    = 6;
  // Headroom of the accumulator above the sample width.
  localparam int ACC_GUARD   = 20;
  // The reciprocal is applied as two 16-bit halves.
  localparam int HALF_W      = 16;
  localparam int FRAC_SHIFT  = 16;

  localparam logic signed [SLOPE_W-1:0] SLOPE_MAX = {1'b0, {(SLOPE_W-1){1'b1}}};
  localparam logic signed [SLOPE_W-1:0] SLOPE_MIN = {1'b1, {(SLOPE_W-1){1'b0}}};

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_MAC,
    ST_SCL_LO,
    ST_SCL_HI,
    ST_DONE
  } lssf_state_t;

  // Commands from the sequencer to the datapath.
  typedef struct packed {
    logic accept;    // write the new sample, update pointer and fill count
    logic setup;     // load tap count, first weight, clear accumulator
    logic issue;     // read the next older sample from the delay line
    logic scale_lo;  // multiply sum by low half of the reciprocal
    logic scale_hi;  // add product with high half of the reciprocal
    logic load_out;  // saturate and move the result to the output register
  } lssf_cmd_t;

  // Status from the datapath to the sequencer.
  typedef struct packed {
    logic issue_done;  // all taps have been read
    logic drain_busy;  // a read is still on its way to the accumulator
    logic out_free;    // output register can take a result this cycle
  } lssf_sts_t;

endpackage

FILE: hw/rtl/lssf_ram.sv
module lssf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data <= mem_r[rd_addr];
  end

endmodule

FILE: hw/rtl/lssf_ctrl.sv
module lssf_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  lssf_pkg::lssf_sts_t sts,
  output lssf_pkg::lssf_cmd_t cmd
);

  import lssf_pkg::*;

  lssf_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = ST_SETUP;
        end
      end
      ST_SETUP: begin
        cmd.setup = 1'b1;
        state_nxt = ST_MAC;
      end
      ST_MAC: begin
        cmd.issue = !sts.issue_done;
        if (sts.issue_done && !sts.drain_busy) begin
          state_nxt = ST_SCL_LO;
        end
      end
      ST_SCL_LO: begin
        cmd.scale_lo = 1'b1;
        state_nxt    = ST_SCL_HI;
      end
      ST_SCL_HI: begin
        cmd.scale_hi = 1'b1;
        state_nxt    = ST_DONE;
      end
      ST_DONE: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

FILE: hw/rtl/lssf_dp.sv
module lssf_dp #(
  parameter int MAX_TAPS     = 128,
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic signed [SAMPLE_WIDTH-1:0]      in_sample,
  input  logic                                in_start_of_block,
  input  logic                                cfg_wr_en,
  input  logic [lssf_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [lssf_pkg::INV_W-1:0]          cfg_wdata,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [lssf_pkg::SLOPE_W-1:0] out_slope,
  input  lssf_pkg::lssf_cmd_t                 cmd,
  output lssf_pkg::lssf_sts_t                 sts
);

  import lssf_pkg::*;

  localparam int AW    = $clog2(MAX_TAPS);
  localparam int CW    = $clog2(MAX_TAPS + 1);
  localparam int TW    = (CW > WINDOW_W) ? CW : WINDOW_W;
  localparam int ACC_W = SAMPLE_WIDTH + ACC_GUARD;
  localparam int MAC_W = SAMPLE_WIDTH + WGT_W;
  localparam int PP_W  = ACC_W + HALF_W + 1;
  localparam int P_W   = ACC_W + INV_W + 1;
  localparam int SAT_LSB = FRAC_SHIFT + SLOPE_W - 1;

  localparam logic [AW-1:0]    LAST_SLOT = AW'(MAX_TAPS - 1);
  localparam logic [CW-1:0]    FULL      = CW'(MAX_TAPS);
  localparam logic [WGT_W-1:0] HALF_WGT  = WGT_W'(WGT_HALF);
  localparam logic [WGT_W-1:0] STEP_WGT  = WGT_W'(WGT_STEP);

  // Configuration registers.
  logic [WINDOW_W-1:0] window_r, window_nxt;
  logic [INV_W-1:0]    inv_r, inv_nxt;

  // Delay line pointers and fill count.
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] fill_r, fill_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          rd_vld_r, rd_vld_nxt;

  // Arithmetic.
  logic signed [WGT_W-1:0]   weight_r, weight_nxt;
  logic signed [ACC_W-1:0]   acc_r, acc_nxt;
  logic signed [P_W-1:0]     prod_r, prod_nxt;
  logic signed [SLOPE_W-1:0] slope_r, slope_nxt;
  logic                      out_valid_r, out_valid_nxt;

  logic [SAMPLE_WIDTH-1:0]        ram_rdata;
  logic [CW-1:0]                  fill_base;
  logic [TW-1:0]                  win_ext, taps_ext, n_ext;
  logic [WGT_W-1:0]               taps_w;
  logic signed [WGT_W-1:0]        weight_first;
  logic signed [MAC_W-1:0]        mac_prod;
  logic [HALF_W-1:0]              inv_half;
  logic signed [PP_W-1:0]         scl_prod;
  logic [P_W-1:SAT_LSB]           top_bits;
  logic                           fits;

  lssf_ram #(
    .WIDTH (SAMPLE_WIDTH),
    .DEPTH (MAX_TAPS)
  ) u_delay (
    .clk     (clk),
    .wr_en   (cmd.accept),
    .wr_addr (wr_ptr_r),
    .wr_data (in_sample),
    .rd_addr (rd_ptr_r),
    .rd_data (ram_rdata)
  );

  always_comb begin
    win_ext  = TW'(window_r);
    taps_ext = (win_ext > TW'(MAX_TAPS)) ? TW'(MAX_TAPS) : win_ext;
    n_ext    = (win_ext < TW'(fill_r)) ? win_ext : TW'(fill_r);
    taps_w   = WGT_W'(taps_ext[WINDOW_W-1:0]);
    weight_first = $signed(HALF_WGT - taps_w * HALF_WGT);
    fill_base = in_start_of_block ? '0 : fill_r;

    mac_prod = $signed(ram_rdata) * weight_r;
    inv_half = cmd.scale_hi ? inv_r[INV_W-1:HALF_W] : inv_r[HALF_W-1:0];
    scl_prod = acc_r * $signed({1'b0, inv_half});

    top_bits = prod_r[P_W-1:SAT_LSB];
    fits     = (&top_bits) || !(|top_bits);
  end

  always_comb begin
    window_nxt    = window_r;
    inv_nxt       = inv_r;
    wr_ptr_nxt    = wr_ptr_r;
    rd_ptr_nxt    = rd_ptr_r;
    fill_nxt      = fill_r;
    cnt_nxt       = cnt_r;
    rd_vld_nxt    = 1'b0;
    weight_nxt    = weight_r;
    acc_nxt       = acc_r;
    prod_nxt      = prod_r;
    slope_nxt     = slope_r;
    out_valid_nxt = out_valid_r && !out_ready;

    if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_WIN_LEN:   window_nxt = cfg_wdata[WINDOW_W-1:0];
        CFG_INV_DENOM: inv_nxt    = cfg_wdata;
        default:       ;
      endcase
    end

    if (cmd.accept) begin
      rd_ptr_nxt = wr_ptr_r;
      wr_ptr_nxt = (wr_ptr_r == LAST_SLOT) ? '0 : wr_ptr_r + AW'(1);
      fill_nxt   = (fill_base < FULL) ? fill_base + CW'(1) : fill_base;
    end

    if (cmd.setup) begin
      cnt_nxt    = CW'(n_ext);
      weight_nxt = weight_first;
      acc_nxt    = '0;
    end

    if (cmd.issue) begin
      rd_vld_nxt = 1'b1;
      cnt_nxt    = cnt_r - CW'(1);
      rd_ptr_nxt = (rd_ptr_r == '0) ? LAST_SLOT : rd_ptr_r - AW'(1);
    end

    if (rd_vld_r) begin
      acc_nxt    = acc_r + ACC_W'(mac_prod);
      weight_nxt = weight_r + $signed(STEP_WGT);
    end

    if (cmd.scale_lo) begin
      prod_nxt = P_W'(scl_prod);
    end
    if (cmd.scale_hi) begin
      prod_nxt = prod_r + (P_W'(scl_prod) <<< HALF_W);
    end

    if (cmd.load_out) begin
      slope_nxt     = fits ? prod_r[SAT_LSB:FRAC_SHIFT]
                           : (prod_r[P_W-1] ? SLOPE_MIN : SLOPE_MAX);
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r    <= WINDOW_RESET;
      inv_r       <= INV_RESET;
      wr_ptr_r    <= '0;
      rd_ptr_r    <= '0;
      fill_r      <= '0;
      cnt_r       <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      window_r    <= window_nxt;
      inv_r       <= inv_nxt;
      wr_ptr_r    <= wr_ptr_nxt;
      rd_ptr_r    <= rd_ptr_nxt;
      fill_r      <= fill_nxt;
      cnt_r       <= cnt_nxt;
      rd_vld_r    <= rd_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    weight_r <= weight_nxt;
    acc_r    <= acc_nxt;
    prod_r   <= prod_nxt;
    slope_r  <= slope_nxt;
  end

  assign sts.issue_done = (cnt_r == '0);
  assign sts.drain_busy = rd_vld_r;
  assign sts.out_free   = !out_valid_r || out_ready;

  assign out_valid = out_valid_r;
  assign out_slope = slope_r;

endmodule

FILE: hw/rtl/least_squares_slope_fir.sv
// Each result takes n delay line reads, n = min(window, fill count), and then waits out
// any hold-off by the receiver. A new sample is taken only once the last result has
// moved into the output register; the pace is set by the single multiply-accumulate
// that reads one delay line entry per cycle.
// Reset: synchronous, active low; clears pointers, fill count and the output valid, and
// loads a window of 80 taps and a reciprocal of 8390. The memory itself is not cleared.
module least_squares_slope_fir #(
  parameter int MAX_TAPS     = 128,
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // Sample channel.
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [SAMPLE_WIDTH-1:0]      in_sample,
  input  logic                                in_start_of_block,
  // Result channel.
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [lssf_pkg::SLOPE_W-1:0] out_slope,
  // Configuration write port.
  input  logic                                cfg_wr_en,
  input  logic [lssf_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [lssf_pkg::INV_W-1:0]          cfg_wdata
);

  import lssf_pkg::*;

  // The sequencer steps each sample through: write into the delay line, set up the
  // tap count and the first weight, walk the history newest to oldest through one
  // multiply-accumulate, apply the reciprocal in two 16-bit halves, then saturate
  // into the output register. A start-of-block sample resets the fill count so that
  // older history reads as absent, which also stands in for clearing the memory.
  // The output register lets the next sample transfer happen while a result waits.

  lssf_cmd_t cmd;
  lssf_sts_t sts;

  lssf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  lssf_dp #(
    .MAX_TAPS     (MAX_TAPS),
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_sample         (in_sample),
    .in_start_of_block (in_start_of_block),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_slope         (out_slope),
    .cmd               (cmd),
    .sts               (sts)
  );

endmodule

FILE: tb/sv/tb_least_squares_slope_fir.sv
`timescale 1ns / 1ps

module tb_least_squares_slope_fir;
  import lssf_pkg::*;

  // The block is built at its default depth and sample width.
  localparam int TAP_DEPTH = 128;
  localparam int SAMPLE_W = 16;

  // Stimulus stops once this many samples have been transferred.
  localparam int ITEM_TARGET = 1150;
  // Long receiver hold-off that lets the block fill up and stall its input.
  localparam int HOLD_CYCLES = 600;
  // Quiet cycles after the last result before the registers are rewritten.
  localparam int SETTLE_CYCLES = 8;
  // Cycles watched for stray results at the end, about one full window.
  localparam int TAIL_CYCLES = TAP_DEPTH + 16;
  // Watchdog bound; the slowest correct run, hold-off included, stays below it.
  localparam longint CYCLE_LIMIT = 1_000_000;

  typedef logic signed [SLOPE_W-1:0] slope_t;
  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef longint unsigned u64_t;

  // One row of the directed table. When set_cfg is high both registers are
  // loaded before the sample is sent. When pinned is high the expected slope
  // is the typed value; otherwise the predictor supplies it.
  typedef struct packed {
    logic                set_cfg;
    logic [WINDOW_W-1:0] window;
    logic [INV_W-1:0]    inv;
    sample_t             smp;
    logic                sob;
    logic                pinned;
    slope_t              slope;
  } dir_row_t;

  localparam int DIR_ROWS_N = 22;
  localparam dir_row_t DIR_ROWS [DIR_ROWS_N] = '{
    // Reset settings: window 80, reciprocal 8390. A zero first sample gives zero.
    '{1'b0, 8'd0, 32'd0, 16'sd0, 1'b1, 1'b1, 34'sd0},
    '{1'b0, 8'd0, 32'd0, 16'sh7FFF, 1'b0, 1'b0, 34'sd0},
    '{1'b0, 8'd0, 32'd0, 16'sh8000, 1'b0, 1'b0, 34'sd0},
    '{1'b0, 8'd0, 32'd0, 16'sd1, 1'b0, 1'b0, 34'sd0},
    '{1'b0, 8'd0, 32'd0, -16'sd1, 1'b0, 1'b0, 34'sd0},
    // A window of one has a single zero weight, a window of zero has no taps.
    '{1'b1, 8'd1, INV_RESET, 16'sh7FFF, 1'b0, 1'b1, 34'sd0},
    '{1'b0, 8'd0, 32'd0, 16'sh8000, 1'b0, 1'b1, 34'sd0},
    '{1'b1, 8'd0, INV_RESET, 16'sd12345, 1'b0, 1'b1, 34'sd0},
    // A zero reciprocal scales every sum to zero, negative sums included.
    '{1'b1, 8'd128, 32'd0, 16'sh7FFF, 1'b1, 1'b1, 34'sd0},
    '{1'b0, 8'd0, 32'd0, 16'sh8000, 1'b0, 1'b1, 34'sd0},
    // Window 2 with the largest reciprocal: full-scale samples overflow 34 bits
    // and saturate toward the sign of the sum (weights are -6 and +6).
    '{1'b1, 8'd2, 32'hFFFF_FFFF, 16'sh8000, 1'b1, 1'b1, SLOPE_MAX},
    '{1'b0, 8'd0, 32'd0, 16'sh7FFF, 1'b0, 1'b1, SLOPE_MIN},
    '{1'b0, 8'd0, 32'd0, 16'sh7FFF, 1'b1, 1'b1, SLOPE_MIN},
    '{1'b0, 8'd0, 32'd0, 16'sd0, 1'b1, 1'b1, 34'sd0},
    // Oversized window falls back to the full tap depth.
    '{1'b1, 8'd255, 32'd2048, 16'sd100, 1'b1, 1'b0, 34'sd0},
    '{1'b0, 8'd0, 32'd0, -16'sd100, 1'b0, 1'b0, 34'sd0},
    '{1'b0, 8'd0, 32'd0, 16'sh7FFF, 1'b0, 1'b0, 34'sd0},
    '{1'b0, 8'd0, 32'd0, 16'sh8000, 1'b0, 1'b0, 34'sd0},
    // Window 3 with its matched reciprocal, round(2^32 / 24).
    '{1'b1, 8'd3, 32'd178956971, 16'sd1000, 1'b1, 1'b0, 34'sd0},
    '{1'b0, 8'd0, 32'd0, -16'sd1000, 1'b0, 1'b0, 34'sd0},
    '{1'b0, 8'd0, 32'd0, 16'sh7FFF, 1'b0, 1'b0, 34'sd0},
    '{1'b0, 8'd0, 32'd0, 16'sh8000, 1'b0, 1'b0, 34'sd0}
  };

  // Every input of the block starts at a known value.
  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  sample_t              in_sample = '0;
  logic                 in_start_of_block = 1'b0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  slope_t               out_slope;
  logic                 cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [INV_W-1:0]     cfg_wdata = '0;

  // Typed expectation that travels with the sample like extra payload, so the
  // checker reads the value that belongs to the transfer at that edge.
  logic   pin_en = 1'b0;
  slope_t pin_slope = '0;

  // Shared control between the sample driver and the result receiver.
  logic        no_idle = 1'b0;
  logic        hold_req = 1'b0;
  int unsigned items_sent = 0;
  int unsigned errors = 0;
  longint      cycles = 0;

  // Shadow of the block: sample history, write slot, fill count, registers.
  sample_t             hist [TAP_DEPTH] = '{default: '0};
  int                  hist_wr = 0;
  int                  hist_fill = 0;
  logic [WINDOW_W-1:0] win_reg = WINDOW_RESET;
  logic [INV_W-1:0]    inv_reg = INV_RESET;

  // Expected slopes in transfer order.
  slope_t slope_q [$];

  least_squares_slope_fir #(
    .MAX_TAPS    (TAP_DEPTH),
    .SAMPLE_WIDTH(SAMPLE_W)
  ) i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_sample        (in_sample),
    .in_start_of_block(in_start_of_block),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_slope        (out_slope),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Takes one sample into the shadow history and returns the slope the block
  // must produce for it. The sum is exact in 64 bits; the reciprocal product
  // has 32 fraction bits and is floored down to 16 before saturation.
  function automatic slope_t predict_slope(sample_t s, logic sob);
    int   taps;
    int   newest;
    longint acc;
    longint base;
    longint wgt;
    u64_t mag;
    u64_t prod;
    u64_t shifted;
    logic neg;
    // A start of block forgets everything older than this sample.
    if (sob) hist_fill = 0;
    newest = hist_wr;
    hist[newest] = s;
    hist_wr = (newest + 1) % TAP_DEPTH;
    if (hist_fill < TAP_DEPTH) hist_fill++;
    taps = (win_reg > TAP_DEPTH) ? TAP_DEPTH : int'(win_reg);
    base = (taps > 0) ? 6 * longint'(taps - 1) : 0;
    acc = 0;
    // Tap k weighs the sample k steps old; missing history counts as zero.
    for (int k = 0; k < taps && k < hist_fill; k++) begin
      wgt = 12 * longint'(k) - base;
      acc += wgt * longint'(hist[(newest + TAP_DEPTH - k) % TAP_DEPTH]);
    end
    neg = (acc < 0);
    mag = neg ? -acc : acc;
    // Products beyond 2^62 are far outside the 34-bit range.
    if (inv_reg != 0 && mag > ((64'd1 << 62) / inv_reg))
      return neg ? SLOPE_MIN : SLOPE_MAX;
    prod = mag * inv_reg;
    if (neg) begin
      // Rounding the magnitude up floors the negative value.
      shifted = (prod + 64'hFFFF) >> 16;
      if (shifted > (64'd1 << 33)) return SLOPE_MIN;
      shifted = -shifted;
      return slope_t'(shifted[SLOPE_W-1:0]);
    end
    shifted = prod >> 16;
    if (shifted > u64_t'(SLOPE_MAX)) return SLOPE_MAX;
    return slope_t'(shifted[SLOPE_W-1:0]);
  endfunction

  // Offers one sample after a random gap and returns at the edge where the
  // transfer happens. Valid stays high into the next call when it has no gap.
  task automatic send_sample(sample_t s, logic sob, logic pin, slope_t pv);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 4);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_sample <= s;
    in_start_of_block <= sob;
    pin_en <= pin;
    pin_slope <= pv;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
  endtask

  // Stops offering samples and waits until every expected slope has been
  // transferred, then lets the block go quiet.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (slope_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes both registers on consecutive edges. The window write carries junk
  // in the upper data bits, which the block must ignore.
  task automatic load_setup(logic [WINDOW_W-1:0] win, logic [INV_W-1:0] inv);
    logic [INV_W-1:0] junk;
    junk = $urandom;
    cfg_wr_en <= 1'b1;
    cfg_index <= CFG_WIN_LEN;
    cfg_wdata <= {junk[INV_W-1:WINDOW_W], win};
    @(posedge clk);
    cfg_index <= CFG_INV_DENOM;
    cfg_wdata <= inv;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    win_reg = win;
    inv_reg = inv;
  endtask

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d slopes outstanding", $time, slope_q.size());
      $display("least_squares_slope_fir: mismatch");
      $finish;
    end
  end

  // Checker. A result transfer is compared before a sample transfer at the
  // same edge is predicted, since that result always belongs to an older sample.
  always @(posedge clk) begin
    slope_t want;
    slope_t predicted;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (slope_q.size() == 0) begin
          errors++;
          $display("%0t: slope expected none actual %0d", $time, out_slope);
        end else begin
          want = slope_q.pop_front();
          if (out_slope !== want) begin
            errors++;
            $display("%0t: slope expected %0d actual %0d", $time, want, out_slope);
          end
        end
      end
      if (in_valid && in_ready) begin
        predicted = predict_slope(in_sample, in_start_of_block);
        slope_q.push_back(pin_en ? pin_slope : predicted);
      end
    end
  end

  // Result receiver. Unless no_idle is set it drops ready for a random stall before
  // each result, and once on request holds ready low for a long stretch while samples keep coming.
  initial begin
    int unsigned stall;
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      stall = no_idle ? 0 : $urandom_range(0, 4);
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!(out_valid && out_ready)) @(posedge clk);
    end
  end

  // Sample driver: reset, the directed table, then random phases. Each phase
  // waits for the block to drain and loads a fresh pair of registers.
  initial begin
    logic [WINDOW_W-1:0] win;
    logic [INV_W-1:0]    inv;
    int      taps;
    longint  denom;
    int      plen;
    int      shape;
    int      ramp;
    int      ramp_inc;
    int      phase_no;
    sample_t s;
    logic    sob;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    foreach (DIR_ROWS[i]) begin
      if (DIR_ROWS[i].set_cfg) begin
        settle();
        load_setup(DIR_ROWS[i].window, DIR_ROWS[i].inv);
      end
      send_sample(DIR_ROWS[i].smp, DIR_ROWS[i].sob, DIR_ROWS[i].pinned, DIR_ROWS[i].slope);
    end

    phase_no = 0;
    while (items_sent < ITEM_TARGET) begin
      // Every phase boundary is a full drain: the sender pauses until all
      // expected slopes have been transferred.
      settle();

      // Mostly legal windows, with the edges and the out-of-range codes mixed in.
      case ($urandom_range(0, 9))
        0:       win = 8'd128;
        1:       win = 8'd2;
        2:       win = WINDOW_W'($urandom_range(129, 255));
        3:       win = WINDOW_W'($urandom_range(0, 1));
        default: win = WINDOW_W'($urandom_range(3, 127));
      endcase
      taps = (win > TAP_DEPTH) ? TAP_DEPTH : int'(win);

      // Usually the matching reciprocal round(2^32 / (W(W^2-1))), sometimes an
      // arbitrary or extreme scale, from zero up to one that drives the result into saturation.
      case ($urandom_range(0, 11))
        0:       inv = '0;
        1:       inv = '1;
        2, 3:    inv = $urandom;
        default: begin
          if (taps < 2) begin
            inv = $urandom;
          end else begin
            denom = longint'(taps) * (longint'(taps) * taps - 1);
            inv = INV_W'(((64'd1 << 33) + denom) / (2 * denom));
          end
        end
      endcase
      load_setup(win, inv);

      no_idle = ($urandom_range(0, 3) == 0);
      if (phase_no == 2) hold_req = 1'b1;

      // Ramps give the filter a true slope to measure; the other shapes are
      // plain noise or full-scale and small values.
      plen = $urandom_range(40, 120);
      shape = $urandom_range(0, 3);
      ramp = int'($urandom_range(0, 16000)) - 8000;
      ramp_inc = int'($urandom_range(0, 400)) - 200;
      for (int n = 0; n < plen && items_sent < ITEM_TARGET; n++) begin
        // Blocks restart now and then, so history runs both short and past
        // the full tap depth across phases.
        sob = (n == 0) ? 1'($urandom_range(0, 1)) : ($urandom_range(0, 47) == 0);
        case (shape)
          0: s = sample_t'($urandom);
          1, 2: begin
            s = sample_t'(ramp + int'($urandom_range(0, 8)) - 4);
            ramp += ramp_inc;
          end
          default: begin
            case ($urandom_range(0, 3))
              0:       s = 16'sh7FFF;
              1:       s = 16'sh8000;
              2:       s = sample_t'(int'($urandom_range(0, 32)) - 16);
              default: s = sample_t'($urandom);
            endcase
          end
        endcase
        send_sample(s, sob, 1'b0, '0);
      end
      phase_no++;
    end

    // All samples are in: drain, then watch a while for stray results.
    settle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0 && slope_q.size() == 0)
      $display("least_squares_slope_fir: match");
    else
      $display("least_squares_slope_fir: mismatch");
    $finish;
  end

endmodule
